### hdl/bpps_pkg.sv
// bpps_pkg: shared types and constants of the blinn-phong pixel shade unit
// no dependencies; compiled first

package bpps_pkg;

    // q.12 fixed point
    localparam int FRAC        = 12;
    localparam int Q_W         = 13;     // magnitude of a q.12 unit value, 0..4096
    localparam int UNIT_Q12    = 4096;
    localparam int LIGHT_COMP  = 2365;   // normalize(1,1,1) in q.12
    localparam int V_PRE_SH    = 8;      // view vector prescale
    localparam int H_PRE_SH    = 4;      // half vector prescale

    // specular exponent, one square-and-multiply stage per bit
    localparam int              POW_STAGES = 6;
    localparam logic [POW_STAGES-1:0] SHININESS = 6'd60;

    // channel sum in 1/40960 output steps
    localparam int AMBIENT_SCALED = 548352;
    localparam int ROUND_HALF     = 20480;
    localparam int OUT_SHIFT      = 13;   // 40960 = 5 << 13
    localparam int SAT_LEVEL      = 1280; // 256 * 5
    localparam int RECIP5         = 52429;
    localparam int RECIP5_SH      = 18;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE_X = 2'd0,
        CFG_EYE_Y = 2'd1,
        CFG_EYE_Z = 2'd2
    } t_cfg_idx;

    typedef logic signed [Q_W:0] t_qv;

    // per pixel data that rides along the pipeline
    typedef struct packed {
        logic signed [13:0] n_x;
        logic signed [13:0] n_y;
        logic signed [13:0] n_z;
        logic [23:0]        kd;
        logic [7:0]         ks;
        logic [23:0]        em;
        logic [Q_W-1:0]     ndl;
    } t_side;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

### hdl/bpps_ifs.sv
// bpps_ifs: handshake interfaces of the pixel, result and configuration channels
// depends on bpps_pkg

interface bpps_pix_in_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] normal_x;
    logic signed [13:0] normal_y;
    logic signed [13:0] normal_z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [23:0]        diffuse_rgb;
    logic [7:0]         specular_level;
    logic [23:0]        emit_rgb;

    modport source (output valid, normal_x, normal_y, normal_z, pos_x, pos_y, pos_z,
                    diffuse_rgb, specular_level, emit_rgb, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, pos_x, pos_y, pos_z,
                    diffuse_rgb, specular_level, emit_rgb, output ready);
endinterface

interface bpps_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bpps_cfg_if;
    import bpps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic signed [15:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bpps_norm3.sv
// bpps_norm3: pipelined 3-vector normalizer to q.12 (square, root, divide)
// depends on bpps_pkg

module bpps_norm3 #(
    parameter int A_W = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][A_W-1:0]    i_mag,
    input  logic [2:0]             i_neg,
    input  bpps_pkg::t_side        i_side,
    output logic                   o_valid,
    output bpps_pkg::t_qv [2:0]    o_vec,
    output bpps_pkg::t_side        o_side
);
    import bpps_pkg::*;

    localparam int S_W = 2 * A_W + 2;
    localparam int R_W = A_W + 1;
    localparam int D_W = A_W + 13;

    typedef struct packed {
        logic [2:0][A_W-1:0] mag;
        logic [2:0]          neg;
        t_side               side;
    } t_carry;

    logic                    r_v0;
    logic [2:0][2*A_W-1:0]   r_sq;
    t_carry                  r_c0;

    logic [R_W:0]            r_sv;
    logic [S_W-1:0]          r_rem  [R_W+1];
    logic [R_W-1:0]          r_root [R_W+1];
    t_carry                  r_sc   [R_W+1];

    logic [Q_W:0]            r_dv;
    logic [R_W-1:0]          r_len  [Q_W+1];
    logic [2:0][D_W-1:0]     r_drem [Q_W+1];
    logic [2:0][Q_W-1:0]     r_q    [Q_W+1];
    logic [2:0]              r_dneg [Q_W+1];
    t_side                   r_dside[Q_W+1];

    logic                    w_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_sv <= '0;
            r_dv <= '0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_sv <= {r_sv[R_W-1:0], r_v0};
            r_dv <= {r_dv[Q_W-1:0], r_sv[R_W]};
        end
    end

    // squares, then their sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*A_W)'(i_mag[i]) * (2*A_W)'(i_mag[i]);
            end
            r_c0      <= '{mag: i_mag, neg: i_neg, side: i_side};
            r_rem[0]  <= S_W'(r_sq[0]) + S_W'(r_sq[1]) + S_W'(r_sq[2]);
            r_root[0] <= '0;
            r_sc[0]   <= r_c0;
        end
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < R_W; g++) begin : g_sqrt
        localparam int K = R_W - 1 - g;
        logic [S_W-1:0] w_trial;
        assign w_trial = (S_W'(r_root[g]) << (K + 1)) | (S_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[g] >= w_trial) begin
                    r_rem[g+1]  <= r_rem[g] - w_trial;
                    r_root[g+1] <= r_root[g] | (R_W'(1) << K);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
                r_sc[g+1] <= r_sc[g];
            end
        end
    end

    // rounded dividend: mag * 4096 + len / 2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= r_root[R_W];
            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= (D_W'(r_sc[R_W].mag[i]) << FRAC) + D_W'(r_root[R_W] >> 1);
            end
            r_q[0]     <= '0;
            r_dneg[0]  <= r_sc[R_W].neg;
            r_dside[0] <= r_sc[R_W].side;
        end
    end

    // restoring divide, one quotient bit per stage, three lanes share the divisor
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int K = Q_W - 1 - j;
        logic [D_W-1:0] w_dvs;
        assign w_dvs = D_W'(r_len[j]) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_drem[j][i] >= w_dvs) begin
                        r_drem[j+1][i] <= r_drem[j][i] - w_dvs;
                        r_q[j+1][i]    <= r_q[j][i] | (Q_W'(1) << K);
                    end else begin
                        r_drem[j+1][i] <= r_drem[j][i];
                        r_q[j+1][i]    <= r_q[j][i];
                    end
                end
                r_len[j+1]   <= r_len[j];
                r_dneg[j+1]  <= r_dneg[j];
                r_dside[j+1] <= r_dside[j];
            end
        end
    end

    // zero length vector normalizes to zero
    assign w_zero = (r_len[Q_W] == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_zero) begin
                o_vec[i] = '0;
            end else if (r_dneg[Q_W][i]) begin
                o_vec[i] = -$signed({1'b0, r_q[Q_W][i]});
            end else begin
                o_vec[i] = $signed({1'b0, r_q[Q_W][i]});
            end
        end
    end

    assign o_valid = r_dv[Q_W];
    assign o_side  = r_dside[Q_W];

endmodule

### hdl/blinn_phong_pixel_shade_unit.sv
// blinn_phong_pixel_shade_unit: top level of the pipelined blinn-phong pixel shader
// depends on bpps_pkg, bpps_ifs and bpps_norm3

// Shades one pixel word per clock while unstalled, with Blinn-Phong lighting, light
// fixed along normalize(1,1,1) and the eye position held in three configuration
// registers (index 0..2 = eye x, y, z; other indexes are ignored; configuration is
// always ready). The datapath is a fully pipelined chain: view vector subtract, a
// normalizer (square, 25-stage bit-serial square root, 13-stage divide), the half
// vector and a second normalizer (18-stage root, 13-stage divide), the N.H dot
// product, six square-and-multiply stages for the power of 60, and three stages
// that mix the channels and round and saturate them. A new pixel word can enter
// every cycle while input ready is high. A skid register behind the output register
// keeps accepting while one result waits; input ready drops only when both hold a
// result, and the whole pipeline then holds still.

module blinn_phong_pixel_shade_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bpps_cfg_if.sink        i_cfg,
    bpps_pix_in_if.sink     i_pix,
    bpps_pix_out_if.source  o_pix
);
    import bpps_pkg::*;

    localparam int V_A_W = 16 + V_PRE_SH;   // |eye - pos| is up to 16 bits
    localparam int H_A_W = 13 + H_PRE_SH;   // |v + l| is up to 13 bits

    function automatic logic [Q_W-1:0] f_cos(input logic signed [29:0] c);
        logic [29:0] t;
        t = 30'(c) + 30'(2048);
        if (c <= 0) begin
            return '0;
        end else if (t[29:FRAC] > 18'(UNIT_Q12)) begin
            return Q_W'(UNIT_Q12);
        end else begin
            return t[FRAC+Q_W-1:FRAC];
        end
    endfunction

    function automatic logic [Q_W-1:0] f_qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(2048);
        return p[FRAC+Q_W-1:FRAC];
    endfunction

    // global advance: the pipeline moves unless the skid register is full
    logic w_en;

    // configuration
    logic signed [15:0] r_eye_x, r_eye_y, r_eye_z;

    // t0: view delta and captured word
    logic                     r_t0_v;
    logic signed [16:0]       r_t0_d [3];
    t_side                    r_t0_side;
    // t1: prescaled magnitudes, n.l
    logic                     r_t1_v;
    logic [2:0][V_A_W-1:0]    r_t1_mag;
    logic [2:0]               r_t1_neg;
    t_side                    r_t1_side;
    t_side                    w_t1_side;
    logic signed [15:0]       w_nsum;
    logic signed [29:0]       w_ndl_c;
    // view normalizer
    logic                     w_v_valid;
    t_qv [2:0]                w_v;
    t_side                    w_v_side;
    // t2: half vector magnitudes
    logic                     r_t2_v;
    logic [2:0][H_A_W-1:0]    r_t2_mag;
    logic [2:0]               r_t2_neg;
    t_side                    r_t2_side;
    logic signed [14:0]       w_h [3];
    logic signed [14:0]       w_ha [3];
    // half vector normalizer
    logic                     w_hn_valid;
    t_qv [2:0]                w_hn;
    t_side                    w_hn_side;
    // t3: n.h products
    logic                     r_t3_v;
    logic signed [27:0]       r_t3_p [3];
    t_side                    r_t3_side;
    // power stages, index 0 holds n.h
    logic [POW_STAGES:0]      r_pv;
    logic [Q_W-1:0]           r_pb [POW_STAGES];
    logic [Q_W-1:0]           r_pr [POW_STAGES+1];
    t_side                    r_pside [POW_STAGES+1];
    // channel stages
    logic                     r_c1_v;
    logic [22:0]              r_c1_dk [3];
    logic [20:0]              r_c1_sp;
    logic [23:0]              r_c1_em;
    logic                     r_c2_v;
    logic [11:0]              r_c2_y [3];
    logic [7:0]               w_ch [3];
    logic [24:0]              w_acc [3];
    logic [27:0]              w_div [3];
    // final stage, output register, skid register
    logic                     r_p_v;
    t_rgb                     r_p_d;
    logic                     r_ov;
    t_rgb                     r_od;
    logic                     r_sv;
    t_rgb                     r_sd;

    assign w_en        = !r_sv;
    assign i_pix.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // eye position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= 16'sd0;
            r_eye_y <= 16'sd0;
            r_eye_z <= 16'sd12288;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_EYE_X: r_eye_x <= i_cfg.data;
                CFG_EYE_Y: r_eye_y <= i_cfg.data;
                CFG_EYE_Z: r_eye_z <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_pv   <= '0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_p_v  <= 1'b0;
        end else if (w_en) begin
            r_t0_v <= i_pix.valid;
            r_t1_v <= r_t0_v;
            r_t2_v <= w_v_valid;
            r_t3_v <= w_hn_valid;
            r_pv   <= {r_pv[POW_STAGES-1:0], r_t3_v};
            r_c1_v <= r_pv[POW_STAGES];
            r_c2_v <= r_c1_v;
            r_p_v  <= r_c2_v;
        end
    end

    // t0: eye minus position
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_d[0] <= 17'(r_eye_x) - 17'(i_pix.pos_x);
            r_t0_d[1] <= 17'(r_eye_y) - 17'(i_pix.pos_y);
            r_t0_d[2] <= 17'(r_eye_z) - 17'(i_pix.pos_z);
            r_t0_side <= '{n_x: i_pix.normal_x, n_y: i_pix.normal_y,
                           n_z: i_pix.normal_z, kd: i_pix.diffuse_rgb,
                           ks: i_pix.specular_level, em: i_pix.emit_rgb, ndl: '0};
        end
    end

    // n.l is l_comp times the component sum
    assign w_nsum  = 16'(r_t0_side.n_x) + 16'(r_t0_side.n_y) + 16'(r_t0_side.n_z);
    assign w_ndl_c = 30'(w_nsum) * 30'(LIGHT_COMP);

    always_comb begin
        w_t1_side     = r_t0_side;
        w_t1_side.ndl = f_cos(w_ndl_c);
    end

    // t1: magnitudes scaled by 256, n.l
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t1_neg[i] <= r_t0_d[i][16];
                r_t1_mag[i] <= r_t0_d[i][16] ? {16'(-r_t0_d[i]), V_PRE_SH'(0)}
                                             : {16'(r_t0_d[i]), V_PRE_SH'(0)};
            end
            r_t1_side <= w_t1_side;
        end
    end

    bpps_norm3 #(.A_W(V_A_W)) u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t1_v),
        .i_mag   (r_t1_mag),
        .i_neg   (r_t1_neg),
        .i_side  (r_t1_side),
        .o_valid (w_v_valid),
        .o_vec   (w_v),
        .o_side  (w_v_side)
    );

    // half vector before normalizing
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_h[i]  = 15'(w_v[i]) + 15'(LIGHT_COMP);
            w_ha[i] = w_h[i][14] ? -w_h[i] : w_h[i];
        end
    end

    // t2: half vector magnitudes scaled by 16
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t2_neg[i] <= w_h[i][14];
                r_t2_mag[i] <= {w_ha[i][12:0], H_PRE_SH'(0)};
            end
            r_t2_side <= w_v_side;
        end
    end

    bpps_norm3 #(.A_W(H_A_W)) u_norm_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t2_v),
        .i_mag   (r_t2_mag),
        .i_neg   (r_t2_neg),
        .i_side  (r_t2_side),
        .o_valid (w_hn_valid),
        .o_vec   (w_hn),
        .o_side  (w_hn_side)
    );

    // t3: n.h products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t3_p[0] <= 28'(w_hn_side.n_x) * 28'(w_hn[0]);
            r_t3_p[1] <= 28'(w_hn_side.n_y) * 28'(w_hn[1]);
            r_t3_p[2] <= 28'(w_hn_side.n_z) * 28'(w_hn[2]);
            r_t3_side <= w_hn_side;
        end
    end

    // power stage 0 sums and clamps n.h, then square and multiply over the
    // exponent bits, one bit per stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pb[0]    <= f_cos(30'(r_t3_p[0]) + 30'(r_t3_p[1]) + 30'(r_t3_p[2]));
            r_pr[0]    <= Q_W'(UNIT_Q12);
            r_pside[0] <= r_t3_side;
            for (int s = 1; s <= POW_STAGES; s++) begin
                r_pr[s]    <= SHININESS[s-1] ? f_qmul(r_pr[s-1], r_pb[s-1]) : r_pr[s-1];
                r_pside[s] <= r_pside[s-1];
            end
            for (int s = 1; s < POW_STAGES; s++) begin
                r_pb[s] <= f_qmul(r_pb[s-1], r_pb[s-1]);
            end
        end
    end

    // c1: diffuse and specular products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_c1_dk[c] <= 23'(r_pside[POW_STAGES].kd[8*(2-c) +: 8])
                              * 23'(15'(r_pside[POW_STAGES].ndl) * 15'(6));
            end
            r_c1_sp <= 21'(r_pside[POW_STAGES].ks) * 21'(r_pr[POW_STAGES]);
            r_c1_em <= r_pside[POW_STAGES].em;
        end
    end

    // c2: channel sum plus half step, divided by 8192
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = 25'(AMBIENT_SCALED) + 25'(ROUND_HALF) + 25'(r_c1_dk[c])
                       + 25'(r_c1_sp)
                       + (25'(11'(r_c1_em[8*(2-c) +: 8]) * 11'(5)) << OUT_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_c2_y[c] <= w_acc[c][24:OUT_SHIFT];
            end
        end
    end

    // c3: divide by 5 through the reciprocal, saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_div[c] = 28'(r_c2_y[c]) * 28'(RECIP5);
            w_ch[c]  = (r_c2_y[c] >= 12'(SAT_LEVEL)) ? 8'hff
                                                      : w_div[c][RECIP5_SH+7:RECIP5_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_d <= '{red: w_ch[0], green: w_ch[1], blue: w_ch[2]};
        end
    end

    // output register with a skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (o_pix.ready) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || o_pix.ready) begin
            r_ov <= r_p_v;
            r_od <= r_p_d;
        end else if (r_p_v) begin
            r_sv <= 1'b1;
            r_sd <= r_p_d;
        end
    end

    assign o_pix.valid = r_ov;
    assign o_pix.red   = r_od.red;
    assign o_pix.green = r_od.green;
    assign o_pix.blue  = r_od.blue;

endmodule

### hdl/bpps_chk.sv
// bpps_chk: port level checks of the pixel shade unit, bound to the top level
// depends on blinn_phong_pixel_shade_unit

module bpps_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_rgb
);
    // words accepted and not yet delivered
    logic [7:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 8'(i_in_valid && i_in_ready) - 8'(i_out_valid && i_out_ready);
        end
    end

    // input stalls only behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without output backpressure");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 8'd0))
        else $error("result word with no accepted pixel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rgb))
        else $error("stalled result word changed");

endmodule

bind blinn_phong_pixel_shade_unit bpps_chk u_bpps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_rgb       ({o_pix.red, o_pix.green, o_pix.blue})
);
